### rtl/rmrd_pkg.sv
// Package with the microcode, its field types and the register codes.
`timescale 1ns / 1ps
`default_nettype none
package rmrd_pkg;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LOADX,
    OP_SQUARE,
    OP_DENOM,
    OP_NUMER,
    OP_DIV,
    OP_SUM_WRITE
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_VALID,
    C_PLAIN,
    C_DIV_MORE,
    C_OUT_BUSY,
    C_SUM
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } uinstr_t;

  typedef struct packed {
    logic in_valid;
    logic restart;
    logic div_more;
    logic out_busy;
  } flags_t;

  localparam pc_t ST_ACCEPT = 4'd0;
  localparam pc_t ST_BRANCH = 4'd1;
  localparam pc_t ST_LOADX  = 4'd2;
  localparam pc_t ST_SQUARE = 4'd3;
  localparam pc_t ST_DENOM  = 4'd4;
  localparam pc_t ST_NUMER  = 4'd5;
  localparam pc_t ST_DIV    = 4'd6;
  localparam pc_t ST_SUM    = 4'd7;
  localparam pc_t ST_WRITE  = 4'd8;
  localparam pc_t ST_RETURN = 4'd9;

  localparam logic [2:0] CFG_ALPHA     = 3'd0;
  localparam logic [2:0] CFG_GAMMA     = 3'd1;
  localparam logic [2:0] CFG_FIXED     = 3'd2;
  localparam logic [2:0] CFG_THRESHOLD = 3'd3;
  localparam logic [2:0] CFG_START     = 3'd4;
  localparam logic [2:0] CFG_TRANSIENT = 3'd5;

  localparam logic [23:0] TRANSIENT_RST = 24'd200000;

  // The division step repeats until the bit counter reaches zero; the sum step
  // only computes the new value, and the write step stalls while the output is held.
  function automatic uinstr_t ucode(input pc_t pc);
    uinstr_t u;
    unique case (pc)
      ST_ACCEPT: u = '{op: OP_ACCEPT,    cond: C_NO_VALID, target: ST_ACCEPT};
      ST_BRANCH: u = '{op: OP_NOP,       cond: C_PLAIN,    target: ST_SQUARE};
      ST_LOADX:  u = '{op: OP_LOADX,     cond: C_ALWAYS,   target: ST_WRITE};
      ST_SQUARE: u = '{op: OP_SQUARE,    cond: C_NEVER,    target: ST_ACCEPT};
      ST_DENOM:  u = '{op: OP_DENOM,     cond: C_NEVER,    target: ST_ACCEPT};
      ST_NUMER:  u = '{op: OP_NUMER,     cond: C_NEVER,    target: ST_ACCEPT};
      ST_DIV:    u = '{op: OP_DIV,       cond: C_DIV_MORE, target: ST_DIV};
      ST_SUM:    u = '{op: OP_LOADX,     cond: C_SUM,      target: ST_WRITE};
      ST_WRITE:  u = '{op: OP_SUM_WRITE, cond: C_OUT_BUSY, target: ST_WRITE};
      ST_RETURN: u = '{op: OP_NOP,       cond: C_ALWAYS,   target: ST_ACCEPT};
      default:   u = '{op: OP_NOP,       cond: C_ALWAYS,   target: ST_ACCEPT};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

### rtl/rmrd_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
`timescale 1ns / 1ps
`default_nettype none
module rmrd_seq import rmrd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output op_e    op_o,
  output cond_e  cond_o
);

  pc_t     pc_q, pc_d;
  uinstr_t uins;
  logic    take;

  always_comb begin
    uins = ucode(pc_q);
  end

  always_comb begin
    case (uins.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_VALID: take = !flags_i.in_valid;
      C_PLAIN:    take = !flags_i.restart;
      C_DIV_MORE: take = flags_i.div_more;
      C_OUT_BUSY: take = flags_i.out_busy;
      C_SUM:      take = 1'b1;
      default:    take = 1'b0;
    endcase
    pc_d = take ? uins.target : pc_t'(pc_q + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_ACCEPT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign op_o   = uins.op;
  assign cond_o = uins.cond;

endmodule
`default_nettype wire

### rtl/rulkov_map_reinjection_detector.sv
// Top level: Rulkov map iterator with reinjection detection and its datapath.
//
// Usage: each beat accepted on the input channel is one tick; restart_i = 1 reloads
// x from the start register and clears the laminar flag and the tick counter.
// Every input beat gives exactly one output beat with x_next_o, offset_o,
// reinjected_o and settled_o. Registers are written through cfg_we_i, cfg_index_i
// and cfg_data_i; indexes beyond the list are ignored. The user must write them
// only while the block is idle; the block itself does not enforce this. A plain
// tick runs the accept, branch, square, denominator and numerator steps, the 32
// steps of the one-bit-per-cycle restoring divider, the sum and the write step;
// a restart runs accept, branch, x load and write. Then the next beat is taken.
// The output register holds a finished result while the receiver stalls; the next
// input beat is still accepted and worked on, and the sequencer waits at its write
// step until the output register is free.
// Reset clears x, the laminar flag, the tick counter and the output valid, and
// loads the register defaults; alpha, gamma and fixed are scaled to FRACTION_BITS.
`timescale 1ns / 1ps
`default_nettype none
module rulkov_map_reinjection_detector import rmrd_pkg::*; #(
  parameter int FRACTION_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] x_next_o,
  output logic [31:0] offset_o,
  output logic        reinjected_o,
  output logic        settled_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int DW = 65 - FRACTION_BITS;
  localparam int NW = 33 + FRACTION_BITS;

  localparam logic [63:0] ALPHA_MAG = ((64'd48 << FRACTION_BITS) + 64'd5) / 64'd10;
  localparam logic [63:0] GAMMA_MAG =
    ((64'd293141 << FRACTION_BITS) + 64'd50000) / 64'd100000;
  localparam logic [63:0] FIXED_MAG =
    ((64'd176493 << FRACTION_BITS) + 64'd50000) / 64'd100000;
  localparam logic [31:0] ALPHA_RST = ALPHA_MAG[31:0];
  localparam logic [31:0] GAMMA_RST = 32'(64'd0 - GAMMA_MAG);
  localparam logic [31:0] FIXED_RST = 32'(64'd0 - FIXED_MAG);
  localparam logic [DW-1:0] ONE_D = DW'(64'd1 << FRACTION_BITS);

  logic [31:0] alpha_q, gamma_q, fixed_q, start_q;
  logic [30:0] thr_q;
  logic [23:0] trans_q;

  logic [31:0] x_q;
  logic        laminar_q;
  logic [23:0] tick_q;
  logic        restart_q;
  logic        out_valid_q;

  logic [63:0]   prod_q;
  logic [DW-1:0] d_q;
  logic [DW-1:0] rem_q;
  logic [31:0]   numlo_q;
  logic [31:0]   quo_q;
  logic [4:0]    cnt_q;
  logic [31:0]   xn_q;

  op_e    op;
  cond_e  cond;
  flags_t flags;
  logic   out_busy, do_write;

  assign out_busy = out_valid_q && !out_ready_i;
  assign do_write = (op == OP_SUM_WRITE) && !out_busy;

  assign flags.in_valid = in_valid_i;
  assign flags.restart  = restart_q;
  assign flags.div_more = (cnt_q != 5'd0);
  assign flags.out_busy = out_busy;

  rmrd_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .op_o    (op),
    .cond_o  (cond)
  );

  assign in_ready_o = (op == OP_ACCEPT);

  logic [31:0]   x_mag, a_mag;
  logic [NW-1:0] num;
  logic [DW:0]   trial;
  logic          qbit;
  logic [33:0]   q_signed, sum;
  logic [31:0]   sum_sat;
  logic [32:0]   fp_ext, dx_s, dx1_s, dx, dx1, thr_ext;
  logic [31:0]   off_sat;
  logic          settled, reinj, laminar_d;
  logic [23:0]   tick_inc;

  always_comb begin
    x_mag = x_q[31] ? 32'(-x_q) : x_q;
    a_mag = alpha_q[31] ? 32'(-alpha_q) : alpha_q;
    num   = (NW'(a_mag) << FRACTION_BITS) + NW'(d_q >> 1);
    trial = {rem_q, numlo_q[31]};
    qbit  = (trial >= {1'b0, d_q});

    q_signed = alpha_q[31] ? 34'(-{2'b00, quo_q}) : {2'b00, quo_q};
    sum      = q_signed + {{2{gamma_q[31]}}, gamma_q};
    if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
      sum_sat = sum[31:0];
    end else begin
      sum_sat = sum[33] ? 32'h8000_0000 : 32'h7fff_ffff;
    end

    fp_ext  = {fixed_q[31], fixed_q};
    dx_s    = {x_q[31], x_q} - fp_ext;
    dx1_s   = {xn_q[31], xn_q} - fp_ext;
    dx      = dx_s[32] ? 33'(-dx_s) : dx_s;
    dx1     = dx1_s[32] ? 33'(-dx1_s) : dx1_s;
    thr_ext = {2'b00, thr_q};
    if (dx1_s[32] == dx1_s[31]) begin
      off_sat = dx1_s[31:0];
    end else begin
      off_sat = dx1_s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end

    settled   = !restart_q && (tick_q >= trans_q);
    reinj     = 1'b0;
    laminar_d = laminar_q;
    if (restart_q) begin
      laminar_d = 1'b0;
    end else if (settled) begin
      if (!laminar_q) begin
        if (dx > thr_ext && dx1 <= thr_ext) begin
          laminar_d = 1'b1;
          reinj     = 1'b1;
        end
      end else if (dx1 > thr_ext) begin
        laminar_d = 1'b0;
      end
    end
    tick_inc = (tick_q == 24'hff_ffff) ? tick_q : 24'(tick_q + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RST;
      gamma_q <= GAMMA_RST;
      fixed_q <= FIXED_RST;
      thr_q   <= '0;
      start_q <= '0;
      trans_q <= TRANSIENT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ALPHA:     alpha_q <= cfg_data_i;
        CFG_GAMMA:     gamma_q <= cfg_data_i;
        CFG_FIXED:     fixed_q <= cfg_data_i;
        CFG_THRESHOLD: thr_q   <= cfg_data_i[30:0];
        CFG_START:     start_q <= cfg_data_i;
        CFG_TRANSIENT: trans_q <= cfg_data_i[23:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      laminar_q   <= 1'b0;
      tick_q      <= '0;
      restart_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (op == OP_ACCEPT && in_valid_i) begin
        restart_q <= restart_i;
      end
      if (do_write) begin
        x_q         <= xn_q;
        laminar_q   <= laminar_d;
        tick_q      <= restart_q ? 24'd0 : tick_inc;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (op)
      OP_LOADX:  xn_q   <= (cond == C_SUM) ? sum_sat : start_q;
      OP_SQUARE: prod_q <= x_mag * x_mag;
      OP_DENOM:  d_q    <= ONE_D + DW'(prod_q >> FRACTION_BITS);
      OP_NUMER: begin
        rem_q   <= DW'(num >> 32);
        numlo_q <= num[31:0];
        cnt_q   <= 5'd31;
      end
      OP_DIV: begin
        rem_q   <= qbit ? DW'(trial - {1'b0, d_q}) : trial[DW-1:0];
        numlo_q <= {numlo_q[30:0], 1'b0};
        quo_q   <= {quo_q[30:0], qbit};
        cnt_q   <= 5'(cnt_q - 1'b1);
      end
      default: ;
    endcase
    if (do_write) begin
      x_next_o     <= xn_q;
      offset_o     <= off_sat;
      reinjected_o <= reinj;
      settled_o    <= settled;
    end
  end

  assign out_valid_o = out_valid_q;

  a_ready_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_DIV) |-> (rem_q < d_q))
    else $error("divider partial remainder not below divisor");

  a_reinj_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reinjected_o) |-> settled_o)
    else $error("reinjection reported on an unsettled tick");

  a_laminar_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(laminar_q) |-> (out_valid_o && reinjected_o))
    else $error("laminar entry without reinjection result");

endmodule
`default_nettype wire

### test/tb_top.sv
// Testbench for the Rulkov map reinjection detector with a cycle-free predictor and checker.
`timescale 1ns / 1ps
module tb_top import rmrd_pkg::*; ();

  localparam int FRAC = 24;
  localparam int HOLD_CYCLES = 300;
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  localparam logic signed [31:0] ALPHA_RST = 32'sd80530637;
  localparam logic signed [31:0] GAMMA_RST = -32'sd49180899;
  localparam logic signed [31:0] FIXED_RST = -32'sd29610612;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh80000000;
  localparam logic signed [63:0] WIDE_MAX = 64'sd2147483647;
  localparam logic signed [63:0] WIDE_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] x_next;
    logic [31:0] offset;
    logic        reinjected;
    logic        settled;
  } map_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        tick_valid;
  logic        tick_ready;
  logic        tick_restart;
  logic        result_valid;
  logic        result_ready;
  logic [31:0] x_next;
  logic [31:0] offset;
  logic        reinjected;
  logic        settled;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  logic signed [31:0] map_alpha = ALPHA_RST;
  logic signed [31:0] map_gamma = GAMMA_RST;
  logic signed [31:0] map_fixed = FIXED_RST;
  logic [30:0]        map_thr = '0;
  logic signed [31:0] map_start = '0;
  logic [23:0]        map_transient = 24'd200000;
  logic signed [31:0] cur_x = '0;
  logic               pred_laminar = 1'b0;
  logic [23:0]        tick_count = '0;

  map_beat_t pending_beats[$];
  int err_count = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  bit hold_results = 1'b0;

  rulkov_map_reinjection_detector #(
    .FRACTION_BITS(FRAC)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (tick_valid),
    .in_ready_o   (tick_ready),
    .restart_i    (tick_restart),
    .out_valid_o  (result_valid),
    .out_ready_i  (result_ready),
    .x_next_o     (x_next),
    .offset_o     (offset),
    .reinjected_o (reinjected),
    .settled_o    (settled),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

  function automatic logic signed [31:0] clamp_word(input logic signed [63:0] v);
    if (v > WIDE_MAX) return WORD_MAX;
    if (v < WIDE_MIN) return WORD_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] map_step(input logic signed [31:0] x);
    logic signed [63:0] xs, as, qs;
    logic [63:0] xm, am, den, quo;
    xs = x;
    as = map_alpha;
    xm = (xs < 0) ? -xs : xs;
    am = (as < 0) ? -as : as;
    den = (64'd1 << FRAC) + ((xm * xm) >> FRAC);
    quo = ((am << FRAC) + (den >> 1)) / den;
    qs = (as < 0) ? -$signed(quo) : $signed(quo);
    return clamp_word(qs + 64'(map_gamma));
  endfunction

  task automatic predict_tick(input logic rs);
    map_beat_t want;
    logic signed [63:0] xo, xn, fp, thr, dx, dx1;
    fp = map_fixed;
    thr = {33'd0, map_thr};
    want.reinjected = 1'b0;
    want.settled = 1'b0;
    if (rs) begin
      cur_x = map_start;
      pred_laminar = 1'b0;
      tick_count = '0;
      xn = map_start;
    end else begin
      xo = cur_x;
      want.settled = (tick_count >= map_transient);
      xn = map_step(cur_x);
      if (want.settled) begin
        dx = xo - fp;
        if (dx < 0) dx = -dx;
        dx1 = xn - fp;
        if (dx1 < 0) dx1 = -dx1;
        if (!pred_laminar) begin
          if (dx > thr && dx1 <= thr) begin
            pred_laminar = 1'b1;
            want.reinjected = 1'b1;
          end
        end else if (dx1 > thr) begin
          pred_laminar = 1'b0;
        end
      end
      if (tick_count != 24'hffffff) tick_count++;
      cur_x = xn[31:0];
    end
    want.x_next = cur_x;
    want.offset = clamp_word(xn - fp);
    pending_beats.push_back(want);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    err_count++;
    if (err_count <= 40)
      $display("Mismatch on %s: expected %h, got %h at %0t ns", what, want, got, $time);
  endtask

  always @(posedge clk_i) begin : check_beat
    map_beat_t want;
    if (rst_ni && result_valid && result_ready) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("unexpected result beat", '0, x_next);
      end else begin
        want = pending_beats.pop_front();
        if (x_next !== want.x_next) report_mismatch("x_next", want.x_next, x_next);
        if (offset !== want.offset) report_mismatch("offset", want.offset, offset);
        if (reinjected !== want.reinjected)
          report_mismatch("reinjected", 32'(want.reinjected), 32'(reinjected));
        if (settled !== want.settled)
          report_mismatch("settled", 32'(want.settled), 32'(settled));
      end
    end
  end

  // The receiver stalls in short random bursts, or once for a long stretch on request.
  initial begin
    result_ready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_results) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_results = 1'b0;
      end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        result_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_tick(input logic rs);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      tick_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    tick_valid <= 1'b1;
    tick_restart <= rs;
    do @(posedge clk_i); while (!tick_ready);
    predict_tick(rs);
  endtask

  task automatic drain_results();
    tick_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  // Upper bits beyond a register's width are filled with noise; the block must drop them.
  task automatic program_map(input logic [31:0] alpha, input logic [31:0] gamma,
                             input logic [31:0] fixed, input logic [30:0] thr,
                             input logic [31:0] start, input logic [23:0] transient);
    drain_results();
    write_reg(CFG_ALPHA, alpha);
    write_reg(CFG_GAMMA, gamma);
    write_reg(CFG_FIXED, fixed);
    write_reg(CFG_THRESHOLD, {1'($urandom_range(0, 1)), thr});
    write_reg(CFG_START, start);
    write_reg(CFG_TRANSIENT, {8'($urandom), transient});
    write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
    cfg_we <= 1'b0;
    map_alpha = alpha;
    map_gamma = gamma;
    map_fixed = fixed;
    map_thr = thr;
    map_start = start;
    map_transient = transient;
  endtask

  task automatic send_run(input int n, input int restart_odds);
    for (int i = 0; i < n; i++) send_tick($urandom_range(0, restart_odds) == 0);
  endtask

  function automatic logic signed [31:0] random_start();
    logic signed [31:0] st;
    st = $urandom_range(0, 83886080);
    return st - 32'sd50331648;
  endfunction

  task automatic test_reset_defaults();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_saturation();
    program_map(WORD_MAX, WORD_MAX, WORD_MIN, 31'h7fffffff, WORD_MAX, 24'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    program_map(WORD_MIN, WORD_MIN, WORD_MAX, 31'd0, WORD_MIN, 24'hffffff);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // With a zero numerator every tick lands exactly on gamma, placed here on the fixed point.
  task automatic test_reinjection();
    program_map(32'd0, FIXED_RST, FIXED_RST, 31'd1, WORD_MAX, 24'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  task automatic test_transient();
    program_map(ALPHA_RST, GAMMA_RST, FIXED_RST, 31'd3355443, -32'sd16777216, 24'd2);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
  endtask

  task automatic test_small_alpha();
    program_map(32'hffffffff, 32'd0, 32'd0, 31'd0, 32'd0, 24'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  task automatic test_rulkov_phases();
    logic [23:0] transient;
    for (int p = 0; p < 4; p++) begin
      transient = (p == 0) ? 24'd0 : 24'($urandom_range(1, 100));
      program_map(ALPHA_RST, GAMMA_RST, FIXED_RST, 31'($urandom_range(167772, 8388608)),
                  random_start(), transient);
      send_tick(1'b1);
      send_run(149, 40);
    end
  endtask

  task automatic test_random_config();
    logic [31:0] alpha, gamma, fixed;
    for (int p = 0; p < 6; p++) begin
      if (p % 2 == 0) begin
        alpha = $urandom;
        gamma = $urandom;
        fixed = $urandom;
        program_map(alpha, gamma, fixed, 31'($urandom), $urandom,
                    24'($urandom_range(0, 20)));
      end else begin
        alpha = ALPHA_RST + $urandom_range(0, 16777216) - 32'd8388608;
        gamma = GAMMA_RST + $urandom_range(0, 4194304) - 32'd2097152;
        fixed = FIXED_RST + $urandom_range(0, 4194304) - 32'd2097152;
        program_map(alpha, gamma, fixed, 31'($urandom_range(0, 16777216)), random_start(),
                    24'($urandom_range(0, 20)));
      end
      send_tick(1'b1);
      send_run(39, 10);
    end
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_output_backpressure();
    program_map(ALPHA_RST, GAMMA_RST, FIXED_RST, 31'd1677722, random_start(), 24'd5);
    hold_results = 1'b1;
    send_tick(1'b1);
    send_run(29, 30);
  endtask

  task automatic test_sender_pause();
    send_run(20, 30);
    tick_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    send_run(20, 30);
  endtask

  task automatic test_full_rate();
    drain_results();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    program_map(ALPHA_RST, GAMMA_RST, FIXED_RST, 31'($urandom_range(167772, 8388608)),
                random_start(), 24'd10);
    send_tick(1'b1);
    send_run(119, 40);
  endtask

  initial begin
    rst_ni = 1'b0;
    tick_valid = 1'b0;
    tick_restart = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ALPHA;
    cfg_data = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    test_reset_defaults();
    test_saturation();
    test_reinjection();
    test_transient();
    test_small_alpha();
    test_rulkov_phases();
    test_random_config();
    test_output_backpressure();
    test_sender_pause();
    test_full_rate();
    drain_results();
    repeat (60) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
